FILE: hdl/pip_pkg.sv
// Shared constants, codes, types and helpers of the point-in-polygon tester.
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 16;

  localparam int ADDR_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * DIFF_W;

  // fixed field widths of the item channels
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FN_TEST   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clear;
    logic append;
    logic walk_start;
    logic step;
    logic out_load;
  } pip_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic last_addr;
    logic busy;
  } pip_sts_t;

  function automatic diff_t sx(input coord_t v);
    return {v[COORD_WIDTH-1], v};
  endfunction

endpackage

FILE: hdl/pip_if.sv
// Item channel interfaces: test/load requests in, results out.
interface pip_in_if;
  logic                               valid;
  logic                               ready;
  logic [pip_pkg::FUNC_W-1:0]         func;
  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_x;
  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_y;

  modport source(output valid, func, coord_x, coord_y, input ready);
  modport sink(input valid, func, coord_x, coord_y, output ready);
endinterface

interface pip_out_if;
  logic                         valid;
  logic                         ready;
  logic                         inside_res;
  logic [pip_pkg::STATUS_W-1:0] status;
  logic [pip_pkg::COUNT_W-1:0]  count_now;

  modport source(output valid, inside_res, status, count_now, input ready);
  modport sink(input valid, inside_res, status, count_now, output ready);
endinterface

FILE: hdl/point_in_polygon_test.sv
// Top level of the point-in-polygon tester (crossing-number rule).
//
//  port    dir  modport  carries
//  in_ch   in   sink     func, coord_x, coord_y (clear / append / test item)
//  out_ch  out  source   inside_res, status, count_now (one result per item)
//
// Clear and append items pass from acceptance through the finish state into the result register.
// In a test over n stored vertices, one RAM read a cycle walks the edges,
// then a three-stage edge pipeline (diffs, products, compare) drains.
// One item is in work at a time; the result register lets the next item in
// while a finished result waits, but a result waits in turn for the register.
// Reset is synchronous, active low; it empties the polygon.
module point_in_polygon_test (
  input logic      clk,
  input logic      rst_n,
  pip_in_if.sink   in_ch,
  pip_out_if.source out_ch
);

  pip_pkg::pip_cmd_t cmd;
  pip_pkg::pip_sts_t sts;

  pip_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_func  (in_ch.func),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pip_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_func   (in_ch.func),
    .in_x      (in_ch.coord_x),
    .in_y      (in_ch.coord_y),
    .out_inside(out_ch.inside_res),
    .out_status(out_ch.status),
    .out_count (out_ch.count_now)
  );

endmodule

FILE: hdl/pip_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/pip_datapath.sv
// Vertex store, edge walk pipeline, crossing parity and result register.
module pip_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pip_pkg::pip_cmd_t            cmd,
  output pip_pkg::pip_sts_t            sts,
  input  logic [pip_pkg::FUNC_W-1:0]   in_func,
  input  pip_pkg::coord_t              in_x,
  input  pip_pkg::coord_t              in_y,
  output logic                         out_inside,
  output logic [pip_pkg::STATUS_W-1:0] out_status,
  output logic [pip_pkg::COUNT_W-1:0]  out_count
);

  localparam int CW = pip_pkg::COORD_WIDTH;

  // control state
  logic [pip_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [pip_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic rv1_r, first1_r, last1_r, close_r, s1_v_r, s2_v_r, parity_r;
  logic parity_nxt;

  // payload
  logic [pip_pkg::FUNC_W-1:0]   func_r;
  logic [pip_pkg::STATUS_W-1:0] status_r, status_nxt;
  pip_pkg::coord_t px_r, py_r, prev_x_r, prev_y_r, first_x_r, first_y_r;
  logic          cond1_r, dypos1_r;
  pip_pkg::diff_t dpx1_r, dy1_r, dpy1_r, dx1_r;
  logic          cond2_r, dypos2_r;
  pip_pkg::prod_t lhs2_r, rhs2_r;
  logic                         out_inside_r;
  logic [pip_pkg::STATUS_W-1:0] out_status_r;
  logic [pip_pkg::COUNT_W-1:0]  out_count_r;

  logic full;
  logic [2*CW-1:0] rd_data;
  pip_pkg::coord_t rd_x, rd_y, ax, ay, bx, by, ymin, ymax, xmax;
  logic edge_v, cond_nxt, hit;
  pip_pkg::diff_t dpx_nxt, dy_nxt, dpy_nxt, dx_nxt;
  pip_pkg::prod_t lhs_nxt, rhs_nxt;

  assign full = (count_r == pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES));

  pip_ram #(
    .WIDTH(2 * CW),
    .DEPTH(pip_pkg::MAX_VERTICES)
  ) u_vert_ram (
    .clk    (clk),
    .wr_en  (cmd.append && !full),
    .wr_addr(count_r[pip_pkg::ADDR_W-1:0]),
    .wr_data({in_x, in_y}),
    .rd_en  (cmd.step),
    .rd_addr(addr_r),
    .rd_data(rd_data)
  );

  assign rd_x = rd_data[2*CW-1:CW];
  assign rd_y = rd_data[CW-1:0];

  assign sts.count_zero = (count_r == '0);
  assign sts.last_addr  = (pip_pkg::CNT_W'(addr_r) + pip_pkg::CNT_W'(1) == count_r);
  assign sts.busy       = rv1_r | close_r | s1_v_r | s2_v_r;

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.append && !full) begin
      count_nxt = count_r + pip_pkg::CNT_W'(1);
    end
    status_nxt = pip_pkg::ST_OK;
    if (in_func == pip_pkg::FN_APPEND && full) begin
      status_nxt = pip_pkg::ST_FULL;
    end else if (in_func == pip_pkg::FN_TEST && count_r == '0) begin
      status_nxt = pip_pkg::ST_EMPTY;
    end
    addr_nxt = addr_r;
    if (cmd.walk_start) begin
      addr_nxt = '0;
    end else if (cmd.step) begin
      addr_nxt = addr_r + pip_pkg::ADDR_W'(1);
    end
  end

  // edge a->b: consecutive vertices, or the closing edge back to the first one
  assign edge_v = (rv1_r && !first1_r) || close_r;
  assign ax = prev_x_r;
  assign ay = prev_y_r;
  assign bx = close_r ? first_x_r : rd_x;
  assign by = close_r ? first_y_r : rd_y;
  assign ymin = (ay < by) ? ay : by;
  assign ymax = (ay < by) ? by : ay;
  assign xmax = (ax < bx) ? bx : ax;
  assign cond_nxt = (py_r > ymin) && (py_r <= ymax) && (px_r <= xmax) && (ay != by);
  assign dpx_nxt = pip_pkg::sx(px_r) - pip_pkg::sx(ax);
  assign dy_nxt  = pip_pkg::sx(by) - pip_pkg::sx(ay);
  assign dpy_nxt = pip_pkg::sx(py_r) - pip_pkg::sx(ay);
  assign dx_nxt  = pip_pkg::sx(bx) - pip_pkg::sx(ax);

  assign lhs_nxt = dpx1_r * dy1_r;
  assign rhs_nxt = dpy1_r * dx1_r;

  // exact crossing test, sense flipped by the sign of dy
  assign hit = cond2_r && (dypos2_r ? (lhs2_r <= rhs2_r) : (lhs2_r >= rhs2_r));

  always_comb begin
    parity_nxt = parity_r;
    if (cmd.walk_start) begin
      parity_nxt = 1'b0;
    end else if (s2_v_r && hit) begin
      parity_nxt = !parity_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      addr_r   <= '0;
      rv1_r    <= 1'b0;
      first1_r <= 1'b0;
      last1_r  <= 1'b0;
      close_r  <= 1'b0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      parity_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      addr_r   <= addr_nxt;
      rv1_r    <= cmd.step;
      first1_r <= (addr_r == '0);
      last1_r  <= sts.last_addr;
      close_r  <= rv1_r && last1_r;
      s1_v_r   <= edge_v;
      s2_v_r   <= s1_v_r;
      parity_r <= parity_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r   <= in_func;
      status_r <= status_nxt;
      px_r     <= in_x;
      py_r     <= in_y;
    end
    if (rv1_r) begin
      prev_x_r <= rd_x;
      prev_y_r <= rd_y;
      if (first1_r) begin
        first_x_r <= rd_x;
        first_y_r <= rd_y;
      end
    end
    cond1_r  <= cond_nxt;
    dypos1_r <= (by > ay);
    dpx1_r   <= dpx_nxt;
    dy1_r    <= dy_nxt;
    dpy1_r   <= dpy_nxt;
    dx1_r    <= dx_nxt;
    cond2_r  <= cond1_r;
    dypos2_r <= dypos1_r;
    lhs2_r   <= lhs_nxt;
    rhs2_r   <= rhs_nxt;
    if (cmd.out_load) begin
      out_inside_r <= (func_r == pip_pkg::FN_TEST) && (status_r == pip_pkg::ST_OK) && parity_r;
      out_status_r <= status_r;
      out_count_r  <= pip_pkg::COUNT_W'(count_r);
    end
  end

  assign out_inside = out_inside_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

endmodule

FILE: hdl/pip_ctrl.sv
// Sequencer: item acceptance, edge walk, pipeline drain and result handoff.
module pip_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pip_pkg::FUNC_W-1:0] in_func,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pip_pkg::pip_cmd_t          cmd,
  input  pip_pkg::pip_sts_t          sts
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_FINISH} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          cmd.clear  = (in_func == pip_pkg::FN_CLEAR);
          cmd.append = (in_func == pip_pkg::FN_APPEND);
          if (in_func == pip_pkg::FN_TEST && !sts.count_zero) begin
            cmd.walk_start = 1'b1;
            state_nxt      = S_WALK;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (sts.last_addr) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a new item never lands on a walk still in flight
  a_quiet_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !sts.busy)
    else $error("item accepted while edge pipeline busy");

  // the walk only runs over a non-empty store
  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> !sts.count_zero)
    else $error("edge walk with no vertices stored");

  // a finished item reaches the output register and frees the input
  a_finish_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && slot_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not handed to output register");

endmodule

FILE: sim/point_in_polygon_test_test.sv
// Testbench for point_in_polygon_test: random polygons and probe points against a scoreboard.
`timescale 1ns / 1ps

module point_in_polygon_test_test;

  typedef logic [pip_pkg::FUNC_W-1:0] func_t;

  localparam func_t FN_UNUSED    = 2'd3;
  localparam int QUIET_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DIRECTED_ITEMS  = 25;
  localparam int PHASE_ITEMS     = 306;
  localparam int DRAIN_CYCLES    = 100;

  typedef enum int {SC_GRID, SC_MEDIUM, SC_FULL, SC_EXTREME} coord_scale_t;

  typedef struct {
    logic                         in_poly;
    logic [pip_pkg::STATUS_W-1:0] status;
    logic [pip_pkg::COUNT_W-1:0]  vcount;
  } pip_result_t;

  // polygon store mirror plus queue of predicted results
  class pip_scoreboard;
    pip_pkg::coord_t vx[pip_pkg::MAX_VERTICES];
    pip_pkg::coord_t vy[pip_pkg::MAX_VERTICES];
    int unsigned     n_held;
    pip_result_t     expected_q[$];
    int              errors;

    function new();
      n_held = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // crossing test for edge a->b, exact by cross-multiplying with the sign of dy
    function bit edge_crossed(longint px, longint py, longint ax, longint ay,
                              longint bx, longint by);
      longint ylo, yhi, xhi, dy, lhs, rhs;
      ylo = (ay < by) ? ay : by;
      yhi = (ay < by) ? by : ay;
      xhi = (ax < bx) ? bx : ax;
      dy  = by - ay;
      if (!(py > ylo && py <= yhi && px <= xhi && dy != 0))
        return 1'b0;
      lhs = (px - ax) * dy;
      rhs = (py - ay) * (bx - ax);
      return (dy > 0) ? (lhs <= rhs) : (lhs >= rhs);
    endfunction

    function void note_item(func_t func, pip_pkg::coord_t x, pip_pkg::coord_t y);
      pip_result_t r;
      int unsigned i, j, crossings;
      r.in_poly = 1'b0;
      r.status  = pip_pkg::ST_OK;
      crossings = 0;
      case (func)
        pip_pkg::FN_CLEAR: n_held = 0;
        pip_pkg::FN_APPEND: begin
          if (n_held < pip_pkg::MAX_VERTICES) begin
            vx[n_held] = x;
            vy[n_held] = y;
            n_held++;
          end else begin
            r.status = pip_pkg::ST_FULL;
          end
        end
        pip_pkg::FN_TEST: begin
          if (n_held == 0) begin
            r.status = pip_pkg::ST_EMPTY;
          end else begin
            for (i = 0; i < n_held; i++) begin
              j = (i + 1 == n_held) ? 0 : i + 1;
              if (edge_crossed(longint'(x), longint'(y),
                               longint'(vx[i]), longint'(vy[i]),
                               longint'(vx[j]), longint'(vy[j])))
                crossings++;
            end
            r.in_poly = crossings[0];
          end
        end
        default: ;
      endcase
      r.vcount = pip_pkg::COUNT_W'(n_held);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic in_poly, logic [pip_pkg::STATUS_W-1:0] status,
                               logic [pip_pkg::COUNT_W-1:0] vcount);
      pip_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual inside_res %0b status %0d count_now %0d",
                 $time, in_poly, status, vcount);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (in_poly !== e.in_poly) begin
        $display("%0t ns: inside_res mismatch, expected %0b actual %0b", $time, e.in_poly, in_poly);
        errors++;
      end
      if (status !== e.status) begin
        $display("%0t ns: status mismatch, expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
      if (vcount !== e.vcount) begin
        $display("%0t ns: count_now mismatch, expected %0d actual %0d", $time, e.vcount, vcount);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pip_in_if  in_ch();
  pip_out_if out_ch();

  point_in_polygon_test u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pip_scoreboard sb = new();

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_off_req = 1'b0;
  int          items_sent   = 0;
  int          quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ch.ready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // sample both channels and keep the watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        sb.note_item(in_ch.func, in_ch.coord_x, in_ch.coord_y);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.inside_res, out_ch.status, out_ch.count_now);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL point_in_polygon_test");
        $finish;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input func_t func, input pip_pkg::coord_t x,
                           input pip_pkg::coord_t y);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.func    = func;
    in_ch.coord_x = x;
    in_ch.coord_y = y;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic pip_pkg::coord_t pick_coord(coord_scale_t scale);
    int v;
    case (scale)
      SC_GRID:   v = int'($urandom_range(8)) - 4;
      SC_MEDIUM: v = int'($urandom_range(2000)) - 1000;
      SC_FULL:   v = int'($urandom);
      default: begin
        case ($urandom_range(4))
          0:       v = -32768;
          1:       v = -32767;
          2:       v = 0;
          3:       v = 32766;
          default: v = 32767;
        endcase
      end
    endcase
    return pip_pkg::coord_t'(v);
  endfunction

  // clear, load a polygon, then probe it; some bursts are plain noise
  task automatic load_and_probe(input bit fill_store);
    coord_scale_t    scale;
    pip_pkg::coord_t poly_x[$];
    pip_pkg::coord_t poly_y[$];
    pip_pkg::coord_t x, y;
    int              n, m, k, a, b, i;
    scale = coord_scale_t'($urandom_range(3));
    k = $urandom_range(99);
    if (!fill_store && k >= 85) begin
      repeat ($urandom_range(1, 6))
        send_item(func_t'($urandom_range(3)), pip_pkg::coord_t'($urandom),
                  pip_pkg::coord_t'($urandom));
      return;
    end
    k = $urandom_range(99);
    if (fill_store || k >= 97)
      n = $urandom_range(pip_pkg::MAX_VERTICES - 2, pip_pkg::MAX_VERTICES + 3);
    else if (k < 75)
      n = $urandom_range(3, 8);
    else if (k < 85)
      n = $urandom_range(1, 2);
    else
      n = $urandom_range(9, 24);
    send_item(pip_pkg::FN_CLEAR, pip_pkg::coord_t'($urandom), pip_pkg::coord_t'($urandom));
    for (i = 0; i < n; i++) begin
      x = pick_coord(scale);
      y = pick_coord(scale);
      if (i < pip_pkg::MAX_VERTICES) begin
        poly_x.push_back(x);
        poly_y.push_back(y);
      end
      send_item(pip_pkg::FN_APPEND, x, y);
    end
    m = $urandom_range(1, 8);
    repeat (m) begin
      k = $urandom_range(99);
      a = $urandom_range(poly_x.size() - 1);
      b = (a + 1) % poly_x.size();
      if (k < 35) begin
        x = pick_coord(scale);
        y = pick_coord(scale);
      end else if (k < 55) begin
        x = poly_x[$urandom_range(poly_x.size() - 1)];
        y = poly_y[$urandom_range(poly_y.size() - 1)];
      end else if (k < 75) begin
        // midpoint of an edge, on the boundary when the sums are even
        x = pip_pkg::coord_t'((longint'(poly_x[a]) + longint'(poly_x[b])) >>> 1);
        y = pip_pkg::coord_t'((longint'(poly_y[a]) + longint'(poly_y[b])) >>> 1);
      end else if (k < 90) begin
        x = pick_coord(scale);
        y = poly_y[a];
      end else begin
        x = pip_pkg::coord_t'($urandom);
        y = pip_pkg::coord_t'($urandom);
      end
      send_item(pip_pkg::FN_TEST, x, y);
    end
  endtask

  initial begin
    int p;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.func    = pip_pkg::FN_CLEAR;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty store, unused code, degenerate and extreme polygons
    send_item(pip_pkg::FN_TEST,   pip_pkg::coord_t'(0),      pip_pkg::coord_t'(0));
    send_item(FN_UNUSED,          pip_pkg::coord_t'(1234),   pip_pkg::coord_t'(-5));
    send_item(pip_pkg::FN_APPEND, pip_pkg::coord_t'(-32768), pip_pkg::coord_t'(-32768));
    send_item(pip_pkg::FN_TEST,   pip_pkg::coord_t'(-32768), pip_pkg::coord_t'(-32768));
    send_item(pip_pkg::FN_APPEND, pip_pkg::coord_t'(32767),  pip_pkg::coord_t'(-32768));
    send_item(pip_pkg::FN_TEST,   pip_pkg::coord_t'(0),      pip_pkg::coord_t'(-32768));
    send_item(pip_pkg::FN_APPEND, pip_pkg::coord_t'(32767),  pip_pkg::coord_t'(32767));
    send_item(pip_pkg::FN_APPEND, pip_pkg::coord_t'(-32768), pip_pkg::coord_t'(32767));
    send_item(pip_pkg::FN_TEST,   pip_pkg::coord_t'(0),      pip_pkg::coord_t'(0));
    send_item(pip_pkg::FN_TEST,   pip_pkg::coord_t'(32767),  pip_pkg::coord_t'(0));
    send_item(pip_pkg::FN_TEST,   pip_pkg::coord_t'(-32768), pip_pkg::coord_t'(0));
    send_item(pip_pkg::FN_TEST,   pip_pkg::coord_t'(0),      pip_pkg::coord_t'(32767));
    send_item(pip_pkg::FN_TEST,   pip_pkg::coord_t'(0),      pip_pkg::coord_t'(-32768));
    send_item(pip_pkg::FN_TEST,   pip_pkg::coord_t'(32767),  pip_pkg::coord_t'(32767));
    send_item(pip_pkg::FN_TEST,   pip_pkg::coord_t'(-32768), pip_pkg::coord_t'(-32768));
    send_item(FN_UNUSED,          pip_pkg::coord_t'(-1),     pip_pkg::coord_t'(-1));
    send_item(pip_pkg::FN_CLEAR,  pip_pkg::coord_t'(32767),  pip_pkg::coord_t'(-32768));
    send_item(pip_pkg::FN_TEST,   pip_pkg::coord_t'(5),      pip_pkg::coord_t'(5));
    send_item(pip_pkg::FN_APPEND, pip_pkg::coord_t'(0),      pip_pkg::coord_t'(0));
    send_item(pip_pkg::FN_APPEND, pip_pkg::coord_t'(10),     pip_pkg::coord_t'(0));
    send_item(pip_pkg::FN_APPEND, pip_pkg::coord_t'(0),      pip_pkg::coord_t'(10));
    send_item(pip_pkg::FN_TEST,   pip_pkg::coord_t'(3),      pip_pkg::coord_t'(3));
    send_item(pip_pkg::FN_TEST,   pip_pkg::coord_t'(5),      pip_pkg::coord_t'(5));
    send_item(pip_pkg::FN_TEST,   pip_pkg::coord_t'(6),      pip_pkg::coord_t'(6));
    send_item(pip_pkg::FN_TEST,   pip_pkg::coord_t'(0),      pip_pkg::coord_t'(5));

    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          hold_off_req = 1'b1;  // sender keeps offering while results back up
        end
        1: begin
          tx_idle_pct  = 63;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 63;
        end
        default: begin
          tx_idle_pct  = 30;
          rx_stall_pct = 30;
        end
      endcase
      load_and_probe(1'b1);
      while (items_sent < DIRECTED_ITEMS + (p + 1) * PHASE_ITEMS)
        load_and_probe(1'b0);
      in_ch.valid = 1'b0;
      // quiet point: let every outstanding result come back
      while (sb.pending() != 0) @(negedge clk);
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS point_in_polygon_test");
    else
      $display("FAIL point_in_polygon_test");
    $finish;
  end

endmodule
